@@ design/dual_channel_pretrigger_capture_core_macros.svh @@
// assertion macros for the pretrigger capture core
`ifndef DUAL_CHANNEL_PRETRIGGER_CAPTURE_CORE_MACROS_SVH
`define DUAL_CHANNEL_PRETRIGGER_CAPTURE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// implication checked every clock, off during reset
`define DCPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked every clock, reset included
`define DCPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DCPC_ASSERT(label, clk, rst, prop, msg)
`define DCPC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ design/dcpc_pkg.sv @@
// shared types and constants of the pretrigger capture core
package dcpc_pkg;

  localparam int MAX_PRE_DEPTH = 1024;
  localparam int ADDR_W        = (MAX_PRE_DEPTH > 1) ? $clog2(MAX_PRE_DEPTH) : 1;
  localparam int SAMPLE_W      = 16;
  localparam int MAG_W         = SAMPLE_W + 1;
  localparam int PRE_W         = 10;
  localparam int POST_W        = 16;
  localparam int CNT_W         = 17;
  localparam int LANES         = 2;
  localparam int ENTRY_W       = LANES * SAMPLE_W;
  localparam int CFG_IDX_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 2'd2;

  // where the delayed pair of an emitting beat comes from
  typedef enum logic [1:0] {
    SEL_BYPASS,
    SEL_STORE,
    SEL_ZERO
  } src_sel_t;

  // hold counter decision for the beat being accepted
  typedef struct packed {
    logic emit;
    logic start;
  } hold_status_t;

  // read stage, lined up with the delay store read data
  typedef struct packed {
    src_sel_t                   sel;
    logic                       start;
    logic [ENTRY_W-1:0]         bypass;
  } read_stage_t;

endpackage

@@ design/dcpc_if.sv @@
// handshake channels of the pretrigger capture core

interface dcpc_sample_if import dcpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;

  modport source (output valid, sample_a, sample_b, input ready);
  modport sink   (input valid, sample_a, sample_b, output ready);
endinterface

interface dcpc_result_if import dcpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_a;
  logic signed [SAMPLE_W-1:0] out_b;
  logic                       event_start;

  modport source (output valid, out_a, out_b, event_start, input ready);
  modport sink   (input valid, out_a, out_b, event_start, output ready);
endinterface

interface dcpc_cfg_if import dcpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/dual_channel_pretrigger_capture_core.sv @@
// top level of the dual channel pretrigger capture core
//
// Takes one beat of two signed 16-bit samples every clock when not stalled and
// keeps them in a 1024-entry delay store. A channel whose 17-bit magnitude is
// above the signed threshold (re)loads the hold counter to pre_count + 1 +
// post_count; while it is nonzero each beat yields one result beat carrying the
// pair from pre_count beats earlier, event_start marking the first beat of a
// capture that starts from an idle counter. Beats that fall outside a capture
// give no result. Throughput is one beat per clock when not stalled, set by the
// delay store taking one write and one read each cycle; a result passes through
// the read stage and then the output register. Two compare lanes run side by
// side, one per channel, and their hits are merged into the hold counter. Store
// entries not yet written since reset read as zero through a wrap flag on the
// write pointer, so no clearing pass is needed after reset. Configuration
// writes are always accepted; write them only while no result is pending.
module dual_channel_pretrigger_capture_core import dcpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  dcpc_sample_if.sink          samples,
  dcpc_result_if.source        results,
  dcpc_cfg_if.sink             cfg
);

`include "dual_channel_pretrigger_capture_core_macros.svh"

  // configuration registers
  logic signed [SAMPLE_W-1:0] threshold;
  logic [PRE_W-1:0]           pre_count;
  logic [POST_W-1:0]          post_count;

  // write side of the delay store
  logic [ADDR_W-1:0]          wp;
  logic                       wrapped;
  logic [ADDR_W-1:0]          delay;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ENTRY_W-1:0]         in_entry;

  // lanes and merge
  logic signed [SAMPLE_W-1:0] lane_sample [LANES];
  logic [LANES-1:0]           hits;
  hold_status_t               hold_st;

  // pipeline
  logic                       in_acc;
  logic                       s1_valid;
  logic                       s1_adv;
  read_stage_t                s1;
  read_stage_t                s1_next;
  logic [ENTRY_W-1:0]         store_rdata;
  logic [ENTRY_W-1:0]         s1_entry;
  logic                       out_valid;
  logic [ENTRY_W-1:0]         out_entry;
  logic                       out_start;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      pre_count  <= '0;
      post_count <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_THRESHOLD:  threshold  <= $signed(cfg.data);
        CFG_PRE_COUNT:  pre_count  <= cfg.data[PRE_W-1:0];
        CFG_POST_COUNT: post_count <= cfg.data[POST_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes: one more beat may enter while a result waits in the output register
  assign s1_adv        = !out_valid || results.ready;
  assign samples.ready = !s1_valid || s1_adv;
  assign in_acc        = samples.valid && samples.ready;

  // delay saturates at the store depth minus one
  assign delay = (32'(pre_count) > MAX_PRE_DEPTH - 1) ? ADDR_W'(MAX_PRE_DEPTH - 1)
                                                       : ADDR_W'(pre_count);

  // read address, wrapping around the store
  always_comb begin
    if (wp >= delay) begin
      rd_addr = wp - delay;
    end else begin
      rd_addr = ADDR_W'((ADDR_W + 1)'(wp) + (ADDR_W + 1)'(MAX_PRE_DEPTH)
                        - (ADDR_W + 1)'(delay));
    end
  end

  assign in_entry = {samples.sample_b, samples.sample_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (in_acc) begin
      if (32'(wp) == MAX_PRE_DEPTH - 1) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + ADDR_W'(1);
      end
    end
  end

  dcpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PRE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp),
    .wdata (in_entry),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  // one compare lane per channel
  assign lane_sample[0] = samples.sample_a;
  assign lane_sample[1] = samples.sample_b;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dcpc_lane u_lane (
      .sample    (lane_sample[g]),
      .threshold (threshold),
      .hit       (hits[g])
    );
  end

  dcpc_hold u_hold (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_acc),
    .hits       (hits),
    .pre_count  (pre_count),
    .post_count (post_count),
    .status     (hold_st)
  );

  // source of the delayed pair: the beat itself, the store, or zero if unwritten
  always_comb begin
    s1_next.start  = hold_st.start;
    s1_next.bypass = in_entry;
    if (delay == '0) begin
      s1_next.sel = SEL_BYPASS;
    end else if (wrapped || (rd_addr < wp)) begin
      s1_next.sel = SEL_STORE;
    end else begin
      s1_next.sel = SEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= hold_st.emit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= s1_next;
    end
  end

  // store read data lines up with the read stage
  always_comb begin
    unique case (s1.sel)
      SEL_BYPASS: s1_entry = s1.bypass;
      SEL_STORE:  s1_entry = store_rdata;
      SEL_ZERO:   s1_entry = '0;
      default:    s1_entry = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_entry <= s1_entry;
      out_start <= s1.start;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_a       = $signed(out_entry[SAMPLE_W-1:0]);
  assign results.out_b       = $signed(out_entry[ENTRY_W-1:SAMPLE_W]);
  assign results.event_start = out_start;

  // a beat outside a capture leaves nothing in the read stage
  `DCPC_ASSERT(a_no_emit_no_result, clk, rst, in_acc && !hold_st.emit |=> !s1_valid, "result staged for a beat outside a capture")
  // a capture start always produces a result beat
  `DCPC_ASSERT(a_start_emits, clk, rst, in_acc && hold_st.start |=> s1_valid && s1.start, "capture start without a staged result")
  // the write pointer moves by one entry per accepted beat
  `DCPC_ASSERT(a_wp_step, clk, rst, in_acc && !$past(rst) |=> (wp == ADDR_W'($past(wp) + ADDR_W'(1))) || (wp == '0), "write pointer skipped an entry")
  // nothing enters the read stage without an accepted beat
  `DCPC_ASSERT_ALWAYS(a_stage_source, clk, !rst && !s1_valid ##1 !rst && s1_valid |-> $past(in_acc), "read stage filled without an input beat")

endmodule

@@ design/dcpc_ram.sv @@
// generic single write port ram with registered read
module dcpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/dcpc_lane.sv @@
// per-channel magnitude compare against the threshold
module dcpc_lane import dcpc_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [SAMPLE_W-1:0] threshold,
  output logic                       hit
);

  logic [MAG_W-1:0] mag;

  // 17-bit magnitude so the most negative code maps to 32768
  always_comb begin
    if (sample[SAMPLE_W-1]) begin
      mag = MAG_W'(0) - {sample[SAMPLE_W-1], sample};
    end else begin
      mag = {1'b0, sample};
    end
  end

  assign hit = $signed({1'b0, mag}) > $signed({{2{threshold[SAMPLE_W-1]}}, threshold});

endmodule

@@ design/dcpc_hold.sv @@
// merges lane hits and runs the capture hold counter
module dcpc_hold import dcpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [LANES-1:0]  hits,
  input  logic [PRE_W-1:0]  pre_count,
  input  logic [POST_W-1:0] post_count,
  output hold_status_t      status
);

  logic [CNT_W-1:0] hold;
  logic [CNT_W-1:0] hold_next;
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] reload;
  logic             trig;

  assign trig   = |hits;
  assign reload = CNT_W'(pre_count) + CNT_W'(post_count) + CNT_W'(1);
  assign loaded = trig ? reload : hold;

  always_comb begin
    status.emit  = (loaded != '0);
    status.start = trig && (hold == '0);
    hold_next    = status.emit ? (loaded - CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept) begin
      hold <= hold_next;
    end
  end

endmodule
